@@ rtl/tlpf_pkg.sv @@
package tlpf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_CLASSES = 3;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int KEY_W   = 8;
  localparam int CLS_W   = 2;
  localparam int TOTAL_W = 6;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] THR_LOW_RST  = 8'd60;
  localparam logic [CFG_W-1:0] THR_HIGH_RST = 8'd80;

  localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH = 1'b1;

  localparam logic [CLS_W-1:0] CLS_LOW  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MID  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_HIGH = 2'd2;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic commit;
    logic load_value;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic deq_hit;
  } dp_stat_t;

endpackage

@@ rtl/tlpf_ram.sv @@
module tlpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/tlpf_ctrl.sv @@
module tlpf_ctrl
  import tlpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold off until the previous beat has left the output register
        if (out_free) begin
          cmd.commit = 1'b1;
          if (stat.deq_hit) begin
            state_nxt = S_READ;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_READ: begin
        cmd.load_value = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

@@ rtl/tlpf_dp.sv @@
module tlpf_dp
  import tlpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_mode,
  input  logic [KEY_W-1:0]     in_key,
  input  ctl_cmd_t             cmd,
  output dp_stat_t             stat,
  output logic [1:0]           res_status,
  output logic [KEY_W-1:0]     res_value,
  output logic [CLS_W-1:0]     res_class,
  output logic [TOTAL_W-1:0]   res_total
);

  logic [CFG_W-1:0] thr_low_r, thr_high_r;

  logic             mode_r;
  logic [KEY_W-1:0] key_r;

  logic [PTR_W-1:0]   head_r  [NUM_CLASSES];
  logic [PTR_W-1:0]   tail_r  [NUM_CLASSES];
  logic [CNT_W-1:0]   count_r [NUM_CLASSES];
  logic [TOTAL_W-1:0] total_r;

  status_t            status_r;
  logic [KEY_W-1:0]   value_r;
  logic [CLS_W-1:0]   class_r;
  logic [TOTAL_W-1:0] tot_out_r;

  logic [CLS_W-1:0]  enq_cls, deq_cls, sel_cls;
  logic              enq_full, any_held;
  status_t           op_status;
  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  sel_ptr;
  logic [ADDR_W-1:0] ram_addr;
  logic [KEY_W-1:0]  ram_rdata;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    if (key_r < thr_low_r) begin
      enq_cls = CLS_LOW;
    end else if (key_r < thr_high_r) begin
      enq_cls = CLS_MID;
    end else begin
      enq_cls = CLS_HIGH;
    end
  end

  assign enq_full = (count_r[enq_cls] == CNT_W'(QUEUE_DEPTH));

  // strict priority: high, then middle, then low
  always_comb begin
    any_held = 1'b1;
    if (count_r[CLS_HIGH] != '0) begin
      deq_cls = CLS_HIGH;
    end else if (count_r[CLS_MID] != '0) begin
      deq_cls = CLS_MID;
    end else begin
      deq_cls  = CLS_LOW;
      any_held = (count_r[CLS_LOW] != '0);
    end
  end

  always_comb begin
    if (mode_r == MODE_ENQ) begin
      sel_cls   = enq_cls;
      op_status = enq_full ? ST_FULL : ST_ENQ;
      sel_ptr   = tail_r[enq_cls];
    end else begin
      sel_cls   = deq_cls;
      op_status = any_held ? ST_DEQ : ST_EMPTY;
      sel_ptr   = head_r[deq_cls];
    end
  end

  assign ram_we   = cmd.commit && (op_status == ST_ENQ);
  assign ram_re   = cmd.commit && (op_status == ST_DEQ);
  assign ram_addr = ADDR_W'(sel_cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(sel_ptr);

  assign stat.deq_hit = (mode_r == MODE_DEQ) && any_held;

  tlpf_ram #(
    .WIDTH (KEY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (key_r),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_low_r  <= THR_LOW_RST;
      thr_high_r <= THR_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THR_LOW:  thr_low_r  <= cfg_wdata;
        CFG_THR_HIGH: thr_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode;
      key_r  <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_r[c]  <= '0;
        tail_r[c]  <= '0;
        count_r[c] <= '0;
      end
      total_r <= '0;
    end else if (cmd.commit) begin
      if (op_status == ST_ENQ) begin
        tail_r[sel_cls]  <= ptr_inc(sel_ptr);
        count_r[sel_cls] <= count_r[sel_cls] + 1'b1;
        total_r          <= total_r + 1'b1;
      end else if (op_status == ST_DEQ) begin
        head_r[sel_cls]  <= ptr_inc(sel_ptr);
        count_r[sel_cls] <= count_r[sel_cls] - 1'b1;
        total_r          <= total_r - 1'b1;
      end
    end
  end

  // result register; held while a beat is stalled at the output
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= op_status;
      value_r  <= '0;
      class_r  <= (op_status == ST_EMPTY) ? CLS_LOW : sel_cls;
      case (op_status)
        ST_ENQ:  tot_out_r <= total_r + 1'b1;
        ST_DEQ:  tot_out_r <= total_r - 1'b1;
        default: tot_out_r <= total_r;
      endcase
    end else if (cmd.load_value) begin
      value_r <= ram_rdata;
    end
  end

  assign res_status = status_r;
  assign res_value  = value_r;
  assign res_class  = class_r;
  assign res_total  = tot_out_r;

endmodule

@@ rtl/three_level_priority_fifo_top.sv @@
// Three strict-priority FIFOs of QUEUE_DEPTH keys each, sharing one 3*QUEUE_DEPTH
// entry store. An enqueue beat (tuser 0) classes its key against threshold_low and
// threshold_high and appends it to the low, middle or high queue, or drops it with
// a full status; a dequeue beat (tuser 1) pops the head of the highest non-empty
// queue, or reports empty. Every input beat gives exactly one result beat. One item
// at a time: an enqueue or an empty/full outcome is written to the result register
// at the commit step, and a successful dequeue adds a read step, as the store read is
// registered. A new item is accepted while the previous result waits at the output; a
// stall there holds the next item at its commit step. Thresholds reset to 60 and 80.
module three_level_priority_fifo_top
  import tlpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] key_value
  input  logic                 in_tuser,   // [0] mode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [1:0] status, [9:2] out_value, [11:10] served_class, [17:12] total_count
  output logic [23:0]          out_tdata
);

  ctl_cmd_t           cmd;
  dp_stat_t           stat;
  logic [1:0]         res_status;
  logic [KEY_W-1:0]   res_value;
  logic [CLS_W-1:0]   res_class;
  logic [TOTAL_W-1:0] res_total;

  tlpf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tlpf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_mode    (in_tuser),
    .in_key     (in_tdata[KEY_W-1:0]),
    .cmd        (cmd),
    .stat       (stat),
    .res_status (res_status),
    .res_value  (res_value),
    .res_class  (res_class),
    .res_total  (res_total)
  );

  assign out_tdata = {6'b0, res_total, res_class, res_value, res_status};

endmodule

@@ rtl/tlpf_checker.sv @@
module tlpf_checker
  import tlpf_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [23:0]          out_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous item in flight");

  // only a dequeue carries a key
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ST_DEQ) |-> out_tdata[9:2] == '0)
    else $error("non-zero value on a non-dequeue result");

  // empty report means nothing is held, class low
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_EMPTY) |-> out_tdata[17:10] == '0)
    else $error("empty result with items held or class set");

endmodule

bind three_level_priority_fifo_top tlpf_checker u_tlpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
